// ===== hdl/quaternion_vector_rotate_top_defines.svh =====
// ----------------------------------------------------------------------------
// Quaternion vector rotation assertion macros
// Concurrent assertion helpers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_VECTOR_ROTATE_TOP_DEFINES_SVH
`define QUATERNION_VECTOR_ROTATE_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define QVR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define QVR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define QVR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define QVR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== hdl/qvr_pkg.sv =====
// ----------------------------------------------------------------------------
// Quaternion vector rotation package
// Shared indexes and counts for the rotation pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package qvr_pkg;

    localparam int NUM_QUAT   = 4;
    localparam int VEC_DIM    = 3;
    localparam int NUM_MAT    = VEC_DIM * VEC_DIM;
    localparam int NUM_STAGES = 6;

    localparam int Q_W = 0;
    localparam int Q_X = 1;
    localparam int Q_Y = 2;
    localparam int Q_Z = 3;

    localparam int P_WW = 0;
    localparam int P_XX = 1;
    localparam int P_YY = 2;
    localparam int P_ZZ = 3;
    localparam int P_XY = 4;
    localparam int P_XZ = 5;
    localparam int P_YZ = 6;
    localparam int P_WX = 7;
    localparam int P_WY = 8;
    localparam int P_WZ = 9;
    localparam int NUM_PRODS = 10;

endpackage

`default_nettype wire

// ===== hdl/qvr_qprod.sv =====
// ----------------------------------------------------------------------------
// Quaternion component products
// First stage: the ten pairwise products of the quaternion components.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qvr_qprod #(
    parameter int QUAT_BITS = 16,
    parameter int VEC_BITS  = 24
) (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic signed [QUAT_BITS-1:0] i_quat [qvr_pkg::NUM_QUAT],
    input  logic signed [VEC_BITS-1:0]  i_vec  [qvr_pkg::VEC_DIM],
    input  logic                       i_dir,
    output logic signed [2*QUAT_BITS-1:0] o_prod [qvr_pkg::NUM_PRODS],
    output logic signed [VEC_BITS-1:0]  o_vec  [qvr_pkg::VEC_DIM],
    output logic                       o_dir
);

    localparam int PW = 2 * QUAT_BITS;

    logic signed [PW-1:0]       n_prod [qvr_pkg::NUM_PRODS];
    logic signed [PW-1:0]       r_prod [qvr_pkg::NUM_PRODS];
    logic signed [VEC_BITS-1:0] r_vec  [qvr_pkg::VEC_DIM];
    logic                       r_dir;

    always_comb begin
        n_prod[qvr_pkg::P_WW] = PW'(i_quat[qvr_pkg::Q_W]) * PW'(i_quat[qvr_pkg::Q_W]);
        n_prod[qvr_pkg::P_XX] = PW'(i_quat[qvr_pkg::Q_X]) * PW'(i_quat[qvr_pkg::Q_X]);
        n_prod[qvr_pkg::P_YY] = PW'(i_quat[qvr_pkg::Q_Y]) * PW'(i_quat[qvr_pkg::Q_Y]);
        n_prod[qvr_pkg::P_ZZ] = PW'(i_quat[qvr_pkg::Q_Z]) * PW'(i_quat[qvr_pkg::Q_Z]);
        n_prod[qvr_pkg::P_XY] = PW'(i_quat[qvr_pkg::Q_X]) * PW'(i_quat[qvr_pkg::Q_Y]);
        n_prod[qvr_pkg::P_XZ] = PW'(i_quat[qvr_pkg::Q_X]) * PW'(i_quat[qvr_pkg::Q_Z]);
        n_prod[qvr_pkg::P_YZ] = PW'(i_quat[qvr_pkg::Q_Y]) * PW'(i_quat[qvr_pkg::Q_Z]);
        n_prod[qvr_pkg::P_WX] = PW'(i_quat[qvr_pkg::Q_W]) * PW'(i_quat[qvr_pkg::Q_X]);
        n_prod[qvr_pkg::P_WY] = PW'(i_quat[qvr_pkg::Q_W]) * PW'(i_quat[qvr_pkg::Q_Y]);
        n_prod[qvr_pkg::P_WZ] = PW'(i_quat[qvr_pkg::Q_W]) * PW'(i_quat[qvr_pkg::Q_Z]);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
            r_vec  <= i_vec;
            r_dir  <= i_dir;
        end
    end

    assign o_prod = r_prod;
    assign o_vec  = r_vec;
    assign o_dir  = r_dir;

endmodule

`default_nettype wire

// ===== hdl/qvr_matrix.sv =====
// ----------------------------------------------------------------------------
// Rotation matrix builder
// Second stage: folds the quaternion products into a 3x3 matrix, with the
// sign of the w cross terms set by the direction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qvr_matrix #(
    parameter int QUAT_BITS = 16,
    parameter int VEC_BITS  = 24
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic signed [2*QUAT_BITS-1:0] i_prod [qvr_pkg::NUM_PRODS],
    input  logic signed [VEC_BITS-1:0]    i_vec  [qvr_pkg::VEC_DIM],
    input  logic                          i_dir,
    output logic signed [2*QUAT_BITS+1:0] o_mat  [qvr_pkg::NUM_MAT],
    output logic signed [VEC_BITS-1:0]    o_vec  [qvr_pkg::VEC_DIM]
);

    localparam int MW = 2 * QUAT_BITS + 2;

    logic signed [MW-1:0]       ww, xx, yy, zz, xy2, xz2, yz2, swx2, swy2, swz2;
    logic signed [MW-1:0]       n_mat [qvr_pkg::NUM_MAT];
    logic signed [MW-1:0]       r_mat [qvr_pkg::NUM_MAT];
    logic signed [VEC_BITS-1:0] r_vec [qvr_pkg::VEC_DIM];

    always_comb begin
        ww   = MW'(i_prod[qvr_pkg::P_WW]);
        xx   = MW'(i_prod[qvr_pkg::P_XX]);
        yy   = MW'(i_prod[qvr_pkg::P_YY]);
        zz   = MW'(i_prod[qvr_pkg::P_ZZ]);
        xy2  = MW'(i_prod[qvr_pkg::P_XY]) <<< 1;
        xz2  = MW'(i_prod[qvr_pkg::P_XZ]) <<< 1;
        yz2  = MW'(i_prod[qvr_pkg::P_YZ]) <<< 1;
        swx2 = MW'(i_prod[qvr_pkg::P_WX]) <<< 1;
        swy2 = MW'(i_prod[qvr_pkg::P_WY]) <<< 1;
        swz2 = MW'(i_prod[qvr_pkg::P_WZ]) <<< 1;
        if (i_dir) begin
            swx2 = -swx2;
            swy2 = -swy2;
            swz2 = -swz2;
        end
        n_mat[0] = ww + xx - yy - zz;
        n_mat[1] = xy2 - swz2;
        n_mat[2] = xz2 + swy2;
        n_mat[3] = xy2 + swz2;
        n_mat[4] = ww - xx + yy - zz;
        n_mat[5] = yz2 - swx2;
        n_mat[6] = xz2 - swy2;
        n_mat[7] = yz2 + swx2;
        n_mat[8] = ww - xx - yy + zz;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mat <= n_mat;
            r_vec <= i_vec;
        end
    end

    assign o_mat = r_mat;
    assign o_vec = r_vec;

endmodule

`default_nettype wire

// ===== hdl/qvr_mul.sv =====
// ----------------------------------------------------------------------------
// Matrix by vector multiplier
// Two stages: each matrix entry is split into a low unsigned half and a high
// signed half, multiplied by its vector component, then recombined.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qvr_mul #(
    parameter int QUAT_BITS = 16,
    parameter int VEC_BITS  = 24
) (
    input  logic                                   i_clk,
    input  logic                                   i_en_a,
    input  logic                                   i_en_b,
    input  logic signed [2*QUAT_BITS+1:0]          i_mat [qvr_pkg::NUM_MAT],
    input  logic signed [VEC_BITS-1:0]             i_vec [qvr_pkg::VEC_DIM],
    output logic signed [2*QUAT_BITS+VEC_BITS+1:0] o_prod [qvr_pkg::NUM_MAT]
);

    localparam int MW  = 2 * QUAT_BITS + 2;
    localparam int LB  = QUAT_BITS + 1;
    localparam int HB  = MW - LB;
    localparam int LOW = LB + 1 + VEC_BITS;
    localparam int HIW = HB + VEC_BITS;
    localparam int PW  = MW + VEC_BITS;

    logic signed [LOW-1:0] n_lo   [qvr_pkg::NUM_MAT];
    logic signed [HIW-1:0] n_hi   [qvr_pkg::NUM_MAT];
    logic signed [LOW-1:0] r_lo   [qvr_pkg::NUM_MAT];
    logic signed [HIW-1:0] r_hi   [qvr_pkg::NUM_MAT];
    logic signed [PW-1:0]  n_prod [qvr_pkg::NUM_MAT];
    logic signed [PW-1:0]  r_prod [qvr_pkg::NUM_MAT];

    always_comb begin
        for (int c = 0; c < qvr_pkg::VEC_DIM; c++) begin
            for (int k = 0; k < qvr_pkg::VEC_DIM; k++) begin
                n_lo[c*qvr_pkg::VEC_DIM+k] =
                    $signed({1'b0, i_mat[c*qvr_pkg::VEC_DIM+k][LB-1:0]}) * i_vec[k];
                n_hi[c*qvr_pkg::VEC_DIM+k] =
                    $signed(i_mat[c*qvr_pkg::VEC_DIM+k][MW-1:LB]) * i_vec[k];
            end
        end
    end

    always_comb begin
        for (int e = 0; e < qvr_pkg::NUM_MAT; e++) begin
            n_prod[e] = (PW'(r_hi[e]) <<< LB) + PW'(r_lo[e]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en_a) begin
            r_lo <= n_lo;
            r_hi <= n_hi;
        end
        if (i_en_b) begin
            r_prod <= n_prod;
        end
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

// ===== hdl/qvr_round.sv =====
// ----------------------------------------------------------------------------
// Accumulate, round and saturate
// Two stages: sums the three products of each row with the rounding half,
// then shifts to the vector format and clips to range.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qvr_round #(
    parameter int QUAT_BITS = 16,
    parameter int VEC_BITS  = 24
) (
    input  logic                                   i_clk,
    input  logic                                   i_en_a,
    input  logic                                   i_en_b,
    input  logic signed [2*QUAT_BITS+VEC_BITS+1:0] i_prod [qvr_pkg::NUM_MAT],
    output logic signed [VEC_BITS-1:0]             o_rot  [qvr_pkg::VEC_DIM],
    output logic                                   o_sat
);

    localparam int PW = 2 * QUAT_BITS + VEC_BITS + 2;
    localparam int AW = PW + 2;
    localparam int SH = 2 * QUAT_BITS - 2;
    localparam logic signed [AW-1:0] HALF =
        $signed({{(AW-SH){1'b0}}, 1'b1, {(SH-1){1'b0}}});
    localparam logic signed [VEC_BITS-1:0] VMAX = $signed({1'b0, {(VEC_BITS-1){1'b1}}});
    localparam logic signed [VEC_BITS-1:0] VMIN = $signed({1'b1, {(VEC_BITS-1){1'b0}}});

    logic signed [AW-1:0]       n_acc [qvr_pkg::VEC_DIM];
    logic signed [AW-1:0]       r_acc [qvr_pkg::VEC_DIM];
    logic signed [VEC_BITS-1:0] n_rot [qvr_pkg::VEC_DIM];
    logic signed [VEC_BITS-1:0] r_rot [qvr_pkg::VEC_DIM];
    logic                       n_sat;
    logic                       r_sat;

    always_comb begin
        for (int c = 0; c < qvr_pkg::VEC_DIM; c++) begin
            n_acc[c] = AW'(i_prod[c*qvr_pkg::VEC_DIM])
                     + AW'(i_prod[c*qvr_pkg::VEC_DIM+1])
                     + AW'(i_prod[c*qvr_pkg::VEC_DIM+2])
                     + HALF;
        end
    end

    always_comb begin
        n_sat = 1'b0;
        for (int c = 0; c < qvr_pkg::VEC_DIM; c++) begin
            if ((&r_acc[c][AW-1:SH+VEC_BITS-1]) || !(|r_acc[c][AW-1:SH+VEC_BITS-1])) begin
                n_rot[c] = $signed(r_acc[c][SH+VEC_BITS-1:SH]);
            end else begin
                n_rot[c] = r_acc[c][AW-1] ? VMIN : VMAX;
                n_sat    = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en_a) begin
            r_acc <= n_acc;
        end
        if (i_en_b) begin
            r_rot <= n_rot;
            r_sat <= n_sat;
        end
    end

    assign o_rot = r_rot;
    assign o_sat = r_sat;

endmodule

`default_nettype wire

// ===== hdl/quaternion_vector_rotate_top.sv =====
// ----------------------------------------------------------------------------
// Quaternion vector rotation
// Rotates a fixed-point vector by a Q1.15 quaternion, either direction,
// with rounding and saturation of the result.
// ----------------------------------------------------------------------------
// The block takes one request per clock unless the pipeline stalls, and
// returns the results in the order accepted. The six register stages are
// quaternion products, rotation matrix, the split vector multiply
// (two stages), row accumulation with rounding, and shift with saturation.
// Each stage has its own valid bit, so when the output side stalls only the
// full stages hold and empty stages keep filling; a new request is taken
// whenever the first stage is empty or moving.
`timescale 1ns / 1ps
`default_nettype none

`include "quaternion_vector_rotate_top_defines.svh"

module quaternion_vector_rotate_top #(
    parameter int QUAT_BITS = 16,
    parameter int VEC_BITS  = 24,
    localparam int S_TW = ((4 * QUAT_BITS + 3 * VEC_BITS + 7) / 8) * 8,
    localparam int M_TW = ((3 * VEC_BITS + 7) / 8) * 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    output logic            o_s_tready,
    // quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z
    input  logic [S_TW-1:0] i_s_tdata,
    // direction
    input  logic [0:0]      i_s_tuser,
    output logic            o_m_tvalid,
    input  logic            i_m_tready,
    // rot_x, rot_y, rot_z
    output logic [M_TW-1:0] o_m_tdata,
    // saturated
    output logic [0:0]      o_m_tuser
);

    localparam int NS = qvr_pkg::NUM_STAGES;
    localparam logic signed [VEC_BITS-1:0] VMAX = $signed({1'b0, {(VEC_BITS-1){1'b1}}});
    localparam logic signed [VEC_BITS-1:0] VMIN = $signed({1'b1, {(VEC_BITS-1){1'b0}}});

    logic [NS-1:0] r_vld;
    logic [NS:0]   w_adv;

    logic signed [QUAT_BITS-1:0]          w_quat  [qvr_pkg::NUM_QUAT];
    logic signed [VEC_BITS-1:0]           w_vec   [qvr_pkg::VEC_DIM];
    logic signed [2*QUAT_BITS-1:0]        w_qprod [qvr_pkg::NUM_PRODS];
    logic signed [VEC_BITS-1:0]           w_vec1  [qvr_pkg::VEC_DIM];
    logic                                 w_dir1;
    logic signed [2*QUAT_BITS+1:0]        w_mat   [qvr_pkg::NUM_MAT];
    logic signed [VEC_BITS-1:0]           w_vec2  [qvr_pkg::VEC_DIM];
    logic signed [2*QUAT_BITS+VEC_BITS+1:0] w_mprod [qvr_pkg::NUM_MAT];
    logic signed [VEC_BITS-1:0]           w_rot   [qvr_pkg::VEC_DIM];
    logic                                 w_sat;

    always_comb begin
        w_adv[NS] = i_m_tready;
        for (int k = NS - 1; k >= 0; k--) begin
            w_adv[k] = !r_vld[k] || w_adv[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_adv[0]) begin
                r_vld[0] <= i_s_tvalid;
            end
            for (int k = 1; k < NS; k++) begin
                if (w_adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_comb begin
        for (int c = 0; c < qvr_pkg::NUM_QUAT; c++) begin
            w_quat[c] = $signed(i_s_tdata[c*QUAT_BITS +: QUAT_BITS]);
        end
        for (int c = 0; c < qvr_pkg::VEC_DIM; c++) begin
            w_vec[c] = $signed(i_s_tdata[qvr_pkg::NUM_QUAT*QUAT_BITS + c*VEC_BITS +: VEC_BITS]);
        end
    end

    qvr_qprod #(
        .QUAT_BITS (QUAT_BITS),
        .VEC_BITS  (VEC_BITS)
    ) u_qprod (
        .i_clk  (i_clk),
        .i_en   (w_adv[0]),
        .i_quat (w_quat),
        .i_vec  (w_vec),
        .i_dir  (i_s_tuser[0]),
        .o_prod (w_qprod),
        .o_vec  (w_vec1),
        .o_dir  (w_dir1)
    );

    qvr_matrix #(
        .QUAT_BITS (QUAT_BITS),
        .VEC_BITS  (VEC_BITS)
    ) u_matrix (
        .i_clk  (i_clk),
        .i_en   (w_adv[1]),
        .i_prod (w_qprod),
        .i_vec  (w_vec1),
        .i_dir  (w_dir1),
        .o_mat  (w_mat),
        .o_vec  (w_vec2)
    );

    qvr_mul #(
        .QUAT_BITS (QUAT_BITS),
        .VEC_BITS  (VEC_BITS)
    ) u_mul (
        .i_clk  (i_clk),
        .i_en_a (w_adv[2]),
        .i_en_b (w_adv[3]),
        .i_mat  (w_mat),
        .i_vec  (w_vec2),
        .o_prod (w_mprod)
    );

    qvr_round #(
        .QUAT_BITS (QUAT_BITS),
        .VEC_BITS  (VEC_BITS)
    ) u_round (
        .i_clk  (i_clk),
        .i_en_a (w_adv[4]),
        .i_en_b (w_adv[5]),
        .i_prod (w_mprod),
        .o_rot  (w_rot),
        .o_sat  (w_sat)
    );

    assign o_s_tready = w_adv[0] && i_rst_n;
    assign o_m_tvalid = r_vld[NS-1];
    assign o_m_tuser  = w_sat;

    always_comb begin
        o_m_tdata = '0;
        for (int c = 0; c < qvr_pkg::VEC_DIM; c++) begin
            o_m_tdata[c*VEC_BITS +: VEC_BITS] = w_rot[c];
        end
    end

    `QVR_ASSERT_NXT(a_accept_fills_first, i_clk, i_rst_n, i_s_tvalid && o_s_tready, r_vld[0], "accepted request did not enter the first stage")
    `QVR_ASSERT_IMP(a_stall_means_full, i_clk, i_rst_n, !o_s_tready, &r_vld, "input stalled while a pipeline stage was empty")
    `QVR_ASSERT_IMP(a_sat_clipped, i_clk, i_rst_n, o_m_tvalid && w_sat, w_rot[0] == VMAX || w_rot[0] == VMIN || w_rot[1] == VMAX || w_rot[1] == VMIN || w_rot[2] == VMAX || w_rot[2] == VMIN, "saturation flag set with no component at a range limit")

endmodule

`default_nettype wire

// ===== dv/quaternion_vector_rotate_top_tb.sv =====
// ----------------------------------------------------------------------------
// Quaternion vector rotation testbench
// Sends quaternion and vector requests in both directions. A local integer
// model predicts each rotated, rounded and clipped result, and the monitor
// checks every returned result in order against that prediction, under
// random stalls on both sides of the stream and a long hold on the output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module quaternion_vector_rotate_top_tb;

    localparam int QB         = 16;
    localparam int VB         = 24;
    localparam int SHIFT      = 2 * QB - 2;
    localparam int S_TW       = ((4 * QB + 3 * VB + 7) / 8) * 8;
    localparam int M_TW       = ((3 * VB + 7) / 8) * 8;
    localparam longint VMAX   = (longint'(1) <<< (VB - 1)) - 1;
    localparam longint VMIN   = -(longint'(1) <<< (VB - 1));
    localparam longint QMAX   = (longint'(1) <<< (QB - 1)) - 1;
    localparam longint QMIN   = -(longint'(1) <<< (QB - 1));
    localparam int PHASE_ITEMS = 600;
    localparam int LONG_HOLD   = 300;
    localparam int SETTLE      = 20;
    localparam int STALL_LIMIT = 4000;

    localparam logic DIR_L2G = 1'b1;

    typedef struct {
        logic              dir;
        logic signed [QB-1:0] qw, qx, qy, qz;
        logic signed [VB-1:0] vx, vy, vz;
    } t_rot_req;

    typedef struct {
        logic signed [VB-1:0] rx, ry, rz;
        logic                 sat;
    } t_rot_res;

    logic            i_clk      = 1'b0;
    logic            i_rst_n    = 1'b0;
    logic            i_s_tvalid = 1'b0;
    logic            o_s_tready;
    logic [S_TW-1:0] i_s_tdata  = '0;
    logic [0:0]      i_s_tuser  = '0;
    logic            o_m_tvalid;
    logic            i_m_tready = 1'b0;
    logic [M_TW-1:0] o_m_tdata;
    logic [0:0]      o_m_tuser;

    t_rot_req pending_reqs[$];
    t_rot_res expected_rots[$];
    t_rot_req drv_req;
    t_rot_req mon_req;
    t_rot_res mon_exp;

    int  src_idle_pct = 29;
    int  snk_idle_pct = 64;
    int  hold_ticket  = 0;
    int  hold_seen    = 0;
    int  hold_left    = 0;
    logic s_taken     = 1'b0;
    int  n_pushed     = 0;
    int  n_accepted   = 0;
    int  n_checked    = 0;
    int  n_sat        = 0;
    int  errors       = 0;
    int  stall_cycles = 0;

    quaternion_vector_rotate_top #(
        .QUAT_BITS(QB),
        .VEC_BITS (VB)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (i_s_tdata),
        .i_s_tuser (i_s_tuser),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata (o_m_tdata),
        .o_m_tuser (o_m_tuser)
    );

    always #4 i_clk = ~i_clk;

    function automatic logic [VB:0] round_clip(longint acc);
        longint      r;
        logic [63:0] lv;
        r = (acc + (longint'(1) <<< (SHIFT - 1))) >>> SHIFT;
        if (r > VMAX) begin
            lv = VMAX;
            return {1'b1, lv[VB-1:0]};
        end
        if (r < VMIN) begin
            lv = VMIN;
            return {1'b1, lv[VB-1:0]};
        end
        lv = r;
        return {1'b0, lv[VB-1:0]};
    endfunction

    function automatic t_rot_res rotate_vector(t_rot_req r);
        longint     w, x, y, z, vx, vy, vz, s, ax, ay, az;
        logic [VB:0] cx, cy, cz;
        t_rot_res   res;
        w  = r.qw;
        x  = r.qx;
        y  = r.qy;
        z  = r.qz;
        vx = r.vx;
        vy = r.vy;
        vz = r.vz;
        s  = (r.dir == DIR_L2G) ? -1 : 1;
        ax = (w*w + x*x - y*y - z*z) * vx + 2 * (x*y - s*w*z) * vy
           + 2 * (x*z + s*w*y) * vz;
        ay = 2 * (x*y + s*w*z) * vx + (w*w - x*x + y*y - z*z) * vy
           + 2 * (y*z - s*w*x) * vz;
        az = 2 * (x*z - s*w*y) * vx + 2 * (y*z + s*w*x) * vy
           + (w*w - x*x - y*y + z*z) * vz;
        cx = round_clip(ax);
        cy = round_clip(ay);
        cz = round_clip(az);
        res.rx  = cx[VB-1:0];
        res.ry  = cy[VB-1:0];
        res.rz  = cz[VB-1:0];
        res.sat = cx[VB] | cy[VB] | cz[VB];
        return res;
    endfunction

    task automatic add_req(logic dir, longint qw, longint qx, longint qy, longint qz,
                           longint vx, longint vy, longint vz);
        t_rot_req r;
        r.dir = dir;
        r.qw  = qw[QB-1:0];
        r.qx  = qx[QB-1:0];
        r.qy  = qy[QB-1:0];
        r.qz  = qz[QB-1:0];
        r.vx  = vx[VB-1:0];
        r.vy  = vy[VB-1:0];
        r.vz  = vz[VB-1:0];
        pending_reqs.push_back(r);
        n_pushed++;
    endtask

    function automatic longint corner_val(longint lo, longint hi);
        case ($urandom_range(4))
            0: return lo;
            1: return -1;
            2: return 0;
            3: return 1;
            default: return hi;
        endcase
    endfunction

    function automatic longint rand_vec();
        case ($urandom_range(3))
            0: return longint'($urandom_range(2000)) - 1000;
            1: return longint'($urandom_range(200000)) - 100000;
            default: return longint'($urandom_range((1 << VB) - 1)) + VMIN;
        endcase
    endfunction

    task automatic rand_req();
        real    a[4];
        real    n;
        longint q[4];
        logic   dir;
        int     mode;
        dir  = $urandom_range(1);
        mode = $urandom_range(9);
        if (mode <= 5) begin
            n = 0.0;
            for (int i = 0; i < 4; i++) begin
                a[i] = (real'($urandom_range(65535)) - 32768.0) / 32768.0;
                n    = n + a[i] * a[i];
            end
            n = $sqrt(n);
            for (int i = 0; i < 4; i++) begin
                q[i] = (n < 0.001) ? ((i == 0) ? QMAX : 0) : $rtoi(a[i] / n * 32767.0);
            end
        end else if (mode <= 7) begin
            for (int i = 0; i < 4; i++) begin
                q[i] = longint'($urandom_range((1 << QB) - 1)) + QMIN;
            end
        end else begin
            for (int i = 0; i < 4; i++) begin
                q[i] = corner_val(QMIN, QMAX);
            end
        end
        if (mode == 9) begin
            add_req(dir, q[0], q[1], q[2], q[3], corner_val(VMIN, VMAX),
                    corner_val(VMIN, VMAX), corner_val(VMIN, VMAX));
        end else begin
            add_req(dir, q[0], q[1], q[2], q[3], rand_vec(), rand_vec(), rand_vec());
        end
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH at result %0d, %s: got %0d, expected %0d",
                 n_checked, what, got, want);
        errors++;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        while (n_accepted != n_pushed || expected_rots.size() != 0) begin
            @(negedge i_clk);
        end
        @(posedge i_clk);
    endtask

    always @(negedge i_clk) begin
        if (!i_s_tvalid || s_taken) begin
            if (i_rst_n && pending_reqs.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                drv_req = pending_reqs.pop_front();
                i_s_tdata  <= {drv_req.vz, drv_req.vy, drv_req.vx,
                               drv_req.qz, drv_req.qy, drv_req.qx, drv_req.qw};
                i_s_tuser  <= drv_req.dir;
                i_s_tvalid <= 1'b1;
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_m_tready <= 1'b0;
            hold_left  <= hold_left - 1;
        end else if (hold_ticket != hold_seen) begin
            hold_seen  <= hold_ticket;
            hold_left  <= LONG_HOLD;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= i_rst_n && ($urandom_range(99) >= snk_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        s_taken <= i_s_tvalid && o_s_tready;
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            mon_req.dir = i_s_tuser[0];
            mon_req.qw  = i_s_tdata[QB-1:0];
            mon_req.qx  = i_s_tdata[2*QB-1:QB];
            mon_req.qy  = i_s_tdata[3*QB-1:2*QB];
            mon_req.qz  = i_s_tdata[4*QB-1:3*QB];
            mon_req.vx  = i_s_tdata[4*QB+VB-1:4*QB];
            mon_req.vy  = i_s_tdata[4*QB+2*VB-1:4*QB+VB];
            mon_req.vz  = i_s_tdata[4*QB+3*VB-1:4*QB+2*VB];
            expected_rots.push_back(rotate_vector(mon_req));
            n_accepted++;
        end
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_rots.size() == 0) begin
                report_mismatch("result with no request waiting", 1, 0);
            end else begin
                mon_exp = expected_rots.pop_front();
                if ($signed(o_m_tdata[VB-1:0]) !== mon_exp.rx) begin
                    report_mismatch("rot_x", $signed(o_m_tdata[VB-1:0]), mon_exp.rx);
                end
                if ($signed(o_m_tdata[2*VB-1:VB]) !== mon_exp.ry) begin
                    report_mismatch("rot_y", $signed(o_m_tdata[2*VB-1:VB]), mon_exp.ry);
                end
                if ($signed(o_m_tdata[3*VB-1:2*VB]) !== mon_exp.rz) begin
                    report_mismatch("rot_z", $signed(o_m_tdata[3*VB-1:2*VB]), mon_exp.rz);
                end
                if (o_m_tuser[0] !== mon_exp.sat) begin
                    report_mismatch("saturated", o_m_tuser[0], mon_exp.sat);
                end
                if (mon_exp.sat) begin
                    n_sat++;
                end
                n_checked++;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles = stall_cycles + 1;
            end
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Timeout: no request moved for %0d cycles", STALL_LIMIT);
                $display("quaternion_vector_rotate_top_tb NOT OK");
                $finish;
            end
        end
    end

    initial begin
        for (int d = 0; d < 2; d++) begin
            add_req(d, QMAX, 0, 0, 0, VMAX, VMIN, 1);
            add_req(d, 0, 0, 0, 0, VMAX, VMAX, VMAX);
            add_req(d, QMIN, 0, 0, 0, VMIN, VMAX, -1);
            add_req(d, QMIN, QMIN, QMIN, QMIN, VMIN, VMIN, VMIN);
            add_req(d, QMAX, QMAX, QMAX, QMAX, VMAX, VMAX, VMAX);
            add_req(d, 23170, 23170, 0, 0, 1000000, 2000000, 3000000);
            add_req(d, 23170, 0, 23170, 0, 1000000, 2000000, 3000000);
            add_req(d, 23170, 0, 0, 23170, 1000000, 2000000, 3000000);
            add_req(d, 0, QMAX, 0, 0, -1, -1, -1);
            // Half an output step exactly: ties must round toward plus infinity.
            add_req(d, 16384, 0, 0, 0, 2, -2, 3);
        end
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < PHASE_ITEMS; i++) begin
            rand_req();
        end
        wait_drained();

        src_idle_pct = 64;
        snk_idle_pct = 29;
        for (int i = 0; i < PHASE_ITEMS; i++) begin
            rand_req();
        end
        wait_drained();

        src_idle_pct = 0;
        snk_idle_pct = 0;
        for (int i = 0; i < PHASE_ITEMS; i++) begin
            rand_req();
        end
        hold_ticket++;
        wait_drained();

        repeat (SETTLE) @(posedge i_clk);
        if (expected_rots.size() != 0) begin
            report_mismatch("results never returned", 0, expected_rots.size());
        end
        $display("Sent %0d rotations in both directions; checked %0d results, %0d clipped.",
                 n_accepted, n_checked, n_sat);
        $display("Stalls: random on both sides, one long output hold, drains between phases.");
        if (errors == 0) begin
            $display("quaternion_vector_rotate_top_tb OK");
        end else begin
            $display("quaternion_vector_rotate_top_tb NOT OK");
        end
        $finish;
    end

endmodule
